### design/u8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
package u8d_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CpW    = 21;
    localparam int unsigned RemW   = 2;
    localparam int unsigned ContW  = 6;

    // lead byte patterns
    localparam logic [7:0] AsciiMask  = 8'h80;
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;
    localparam logic [7:0] PayloadTop = 8'h7F;
    localparam logic [7:0] ContMask   = 8'h3F;

    // bytes still expected after a lead byte
    localparam logic [RemW-1:0] RemNone = 2'd0;
    localparam logic [RemW-1:0] RemOne  = 2'd1;
    localparam logic [RemW-1:0] RemTwo  = 2'd2;
    localparam logic [RemW-1:0] RemThree = 2'd3;

    typedef struct packed {
        logic [RemW-1:0] bytes_remaining;
        logic [CpW-1:0]  partial_value;
    } t_dec_state;

    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [CpW-1:0] code_point;
        logic           truncated;
    } t_out_item;

    typedef struct packed {
        logic       emit;
        t_out_item  item;
        t_dec_state next_state;
    } t_step_res;

endpackage

### design/u8d_if.sv
// valid/ready channel interfaces for bytes in and code points out
interface u8d_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::ByteW-1:0]    data_byte;
    logic                         end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface u8d_cp_if;
    logic                         valid;
    logic                         ready;
    logic [u8d_pkg::CpW-1:0]      code_point;
    logic                         truncated;

    modport source (output valid, output code_point, output truncated, input ready);
    modport sink   (input valid, input code_point, input truncated, output ready);
endinterface

### design/u8d_step.sv
// one-byte decode step: current state and byte in, next state and result out
module u8d_step (
    input  u8d_pkg::t_dec_state i_state,
    input  u8d_pkg::t_in_item   i_item,
    output u8d_pkg::t_step_res  o_res
);

    logic [7:0]                  b;
    logic [u8d_pkg::CpW-1:0]     shifted;
    logic [u8d_pkg::RemW-1:0]    rem_dec;
    logic [u8d_pkg::RemW-1:0]    lead_rem;
    logic [7:0]                  lead_mask;

    assign b       = i_item.data_byte;
    assign shifted = {i_state.partial_value[u8d_pkg::CpW-u8d_pkg::ContW-1:0],
                      b[u8d_pkg::ContW-1:0] & u8d_pkg::ContMask[u8d_pkg::ContW-1:0]};
    assign rem_dec = i_state.bytes_remaining - u8d_pkg::RemOne;

    // lead byte classification, zero remaining means single byte
    always_comb begin
        lead_rem  = u8d_pkg::RemNone;
        lead_mask = u8d_pkg::PayloadTop;
        if ((b & u8d_pkg::AsciiMask) == 8'h00) begin
            lead_rem = u8d_pkg::RemNone;
        end else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code) begin
            lead_rem  = u8d_pkg::RemOne;
            lead_mask = u8d_pkg::PayloadTop >> 2;
        end else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code) begin
            lead_rem  = u8d_pkg::RemTwo;
            lead_mask = u8d_pkg::PayloadTop >> 3;
        end else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code) begin
            lead_rem  = u8d_pkg::RemThree;
            lead_mask = u8d_pkg::PayloadTop >> 4;
        end
    end

    always_comb begin
        o_res.emit            = 1'b0;
        o_res.item.code_point = '0;
        o_res.item.truncated  = 1'b0;
        o_res.next_state      = i_state;
        if (i_state.bytes_remaining == u8d_pkg::RemNone) begin
            if (lead_rem == u8d_pkg::RemNone) begin
                // ascii or invalid lead, pass the raw byte
                o_res.emit            = 1'b1;
                o_res.item.code_point = {{(u8d_pkg::CpW-8){1'b0}}, b};
            end else if (i_item.end_of_input) begin
                o_res.emit            = 1'b1;
                o_res.item.code_point = {{(u8d_pkg::CpW-8){1'b0}}, b & lead_mask};
                o_res.item.truncated  = 1'b1;
                o_res.next_state      = '0;
            end else begin
                o_res.next_state.bytes_remaining = lead_rem;
                o_res.next_state.partial_value   =
                    {{(u8d_pkg::CpW-8){1'b0}}, b & lead_mask};
            end
        end else begin
            if (rem_dec == u8d_pkg::RemNone) begin
                o_res.emit            = 1'b1;
                o_res.item.code_point = shifted;
                o_res.next_state      = '0;
            end else if (i_item.end_of_input) begin
                o_res.emit            = 1'b1;
                o_res.item.code_point = shifted;
                o_res.item.truncated  = 1'b1;
                o_res.next_state      = '0;
            end else begin
                o_res.next_state.bytes_remaining = rem_dec;
                o_res.next_state.partial_value   = shifted;
            end
        end
    end

endmodule

### design/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder: input register, decode step, result register
// path from byte accepted to code point shown: input register, then result register
// throughput: one byte per cycle unless the receiver stalls; the decode step is combinational
// a byte that closes no sequence produces no item and frees its slot in the same cycle
// reset: synchronous active-low i_rst_n clears both valid flags and the sequence state
module utf8_stream_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8d_byte_if.sink      i_byte,
    u8d_cp_if.source      o_cp
);

    // input register
    logic                r_in_valid;
    u8d_pkg::t_in_item   r_in;

    // decoder state (open sequence)
    u8d_pkg::t_dec_state r_state;

    // result register
    logic                r_out_valid;
    u8d_pkg::t_out_item  r_out;

    u8d_pkg::t_in_item   n_in;
    u8d_pkg::t_step_res  step_res;
    logic                out_free;
    logic                advance;
    logic                in_take;

    assign n_in.data_byte    = i_byte.data_byte;
    assign n_in.end_of_input = i_byte.end_of_input;

    u8d_step u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .o_res   (step_res)
    );

    // the result slot is free if empty or being taken this cycle
    assign out_free = !r_out_valid || o_cp.ready;
    // the held byte moves on when its result has a place or it makes no result
    assign advance  = r_in_valid && (out_free || !step_res.emit);
    // a new byte enters when the input register empties or moves on
    assign i_byte.ready = !r_in_valid || advance;
    assign in_take      = i_byte.valid && i_byte.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= n_in;
        end
    end

    // sequence state only moves when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= step_res.next_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_cp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_res.emit) begin
            r_out <= step_res.item;
        end
    end

    assign o_cp.valid      = r_out_valid;
    assign o_cp.code_point = r_out.code_point;
    assign o_cp.truncated  = r_out.truncated;

endmodule

### verif/utf8_stream_decoder_tb.sv
// testbench for the utf-8 stream decoder: directed and random byte streams checked against a predictor
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #5 i_clk = ~i_clk;

    // byte channel in, code point channel out
    u8d_byte_if byte_ch ();
    u8d_cp_if   cp_ch ();

    utf8_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch.sink),
        .o_cp    (cp_ch.source)
    );

    // decoder state as the predictor sees it
    logic [u8d_pkg::RemW-1:0] rem_bytes = u8d_pkg::RemNone;
    logic [u8d_pkg::CpW-1:0]  acc_val   = '0;

    // code points still owed by the block, oldest first
    u8d_pkg::t_out_item cp_expect_q[$];

    // traffic shaping knobs
    bit sender_idle_en = 1'b1;
    bit sink_stall_en  = 1'b1;
    int burst_left     = 0;
    int stall_left     = 0;

    // bookkeeping
    int fail_count   = 0;
    int bytes_sent   = 0;
    int cps_checked  = 0;
    int trunc_seen   = 0;

    // one decode step on the predictor state; returns 1 when a code point comes out
    function automatic logic decode_step(input logic [u8d_pkg::ByteW-1:0] b, input logic eoi,
                                         output u8d_pkg::t_out_item res);
        logic [2:0]                seq_len;
        logic [u8d_pkg::ByteW-1:0] low_bits;
        res = '0;
        low_bits = b & u8d_pkg::ContMask;
        if (rem_bytes == u8d_pkg::RemNone) begin
            // lead byte picks the sequence length
            if ((b & u8d_pkg::AsciiMask) == 8'h00)                     seq_len = 3'd1;
            else if ((b & u8d_pkg::Lead2Mask) == u8d_pkg::Lead2Code)   seq_len = 3'd2;
            else if ((b & u8d_pkg::Lead3Mask) == u8d_pkg::Lead3Code)   seq_len = 3'd3;
            else if ((b & u8d_pkg::Lead4Mask) == u8d_pkg::Lead4Code)   seq_len = 3'd4;
            else                                                       seq_len = 3'd1;
            // ascii and invalid leads pass straight through, even with end of input
            if (seq_len == 3'd1) begin
                res.code_point = u8d_pkg::CpW'(b);
                return 1'b1;
            end
            acc_val   = u8d_pkg::CpW'(b & (u8d_pkg::PayloadTop >> seq_len));
            rem_bytes = u8d_pkg::RemW'(seq_len - 3'd1);
        end else begin
            // no continuation check: low six bits shift in regardless
            acc_val   = {acc_val[u8d_pkg::CpW-u8d_pkg::ContW-1:0],
                         low_bits[u8d_pkg::ContW-1:0]};
            rem_bytes = rem_bytes - u8d_pkg::RemOne;
            if (rem_bytes == u8d_pkg::RemNone) begin
                res.code_point = acc_val;
                acc_val = '0;
                return 1'b1;
            end
        end
        // buffer ended with the sequence still open
        if (eoi) begin
            res.code_point = acc_val;
            res.truncated  = 1'b1;
            rem_bytes      = u8d_pkg::RemNone;
            acc_val        = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // drive one item and wait for the handshake; sender idles between random bursts when enabled
    task automatic send_byte(input logic [u8d_pkg::ByteW-1:0] b, input logic eoi);
        u8d_pkg::t_out_item res;
        int                 gap;
        if (sender_idle_en && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.data_byte    <= b;
        byte_ch.end_of_input <= eoi;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        bytes_sent++;
        if (decode_step(b, eoi, res)) cp_expect_q.push_back(res);
    endtask

    // stop sending until every owed code point has come back
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cp_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ascii extremes, invalid lead bytes, end of input on a plain byte
    task automatic test_single_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
    endtask

    // two-byte min and max, three- and four-byte max payloads, plus a non-continuation tail byte
    task automatic test_multibyte();
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
    endtask

    // end of input mid-sequence, on a lone lead byte, and on the closing byte
    task automatic test_end_of_input();
        send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
        send_byte(8'hF0, 1'b1);
        send_byte(8'hC2, 1'b0); send_byte(8'hA9, 1'b1);
    endtask

    // one random sequence: mostly well formed, some cut short, some garbage
    task automatic send_random_seq();
        int seq_len;
        int kind;
        int cut;
        logic [u8d_pkg::ByteW-1:0] lead;
        seq_len = $urandom_range(1, 4);
        kind    = $urandom_range(0, 9);
        case (seq_len)
            1:       lead = u8d_pkg::ByteW'($urandom_range(0, 127));
            2:       lead = u8d_pkg::Lead2Code | u8d_pkg::ByteW'($urandom_range(0, 31));
            3:       lead = u8d_pkg::Lead3Code | u8d_pkg::ByteW'($urandom_range(0, 15));
            default: lead = u8d_pkg::Lead4Code | u8d_pkg::ByteW'($urandom_range(0, 7));
        endcase
        if (kind == 0) begin
            // raw noise byte, often an invalid lead
            send_byte(u8d_pkg::ByteW'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end else if (kind == 1 && seq_len > 1) begin
            // buffer ends partway through
            cut = $urandom_range(1, seq_len - 1);
            for (int i = 0; i < cut; i++)
                send_byte(i == 0 ? lead :
                          (u8d_pkg::AsciiMask | u8d_pkg::ByteW'($urandom_range(0, 63))),
                          i == cut - 1);
        end else begin
            send_byte(lead, (seq_len == 1) && ($urandom_range(0, 9) == 0));
            for (int i = 1; i < seq_len; i++) begin
                // kind 2 puts arbitrary bytes in the tail
                if (kind == 2)
                    send_byte(u8d_pkg::ByteW'($urandom_range(0, 255)),
                              (i == seq_len - 1) && ($urandom_range(0, 9) == 0));
                else
                    send_byte(u8d_pkg::AsciiMask | u8d_pkg::ByteW'($urandom_range(0, 63)),
                              (i == seq_len - 1) && ($urandom_range(0, 9) == 0));
            end
        end
    endtask

    // random streams in four traffic mixes, draining between them
    task automatic test_random_stream();
        int stop_at;
        for (int mix = 0; mix < 4; mix++) begin
            sender_idle_en = (mix == 0) || (mix == 2);
            sink_stall_en  = (mix == 0) || (mix == 3);
            burst_left     = 0;
            stop_at        = bytes_sent + 480;
            while (bytes_sent < stop_at) send_random_seq();
            drain_results();
        end
    endtask

    // receiver: random stall stretches, or always ready when stalls are off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cp_ch.ready <= 1'b0;
        end else if (!sink_stall_en) begin
            cp_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            cp_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(0, 6);
            cp_ch.ready <= 1'b0;
        end else begin
            cp_ch.ready <= 1'b1;
        end
    end

    // result checker: every accepted code point against the oldest prediction
    always @(posedge i_clk) begin : cp_check
        u8d_pkg::t_out_item exp_item;
        if (i_rst_n && cp_ch.valid && cp_ch.ready) begin
            if (cp_expect_q.size() == 0) begin
                $error("unexpected item: code_point %h truncated %b",
                       cp_ch.code_point, cp_ch.truncated);
                fail_count++;
            end else begin
                exp_item = cp_expect_q.pop_front();
                cps_checked++;
                if (cp_ch.truncated) trunc_seen++;
                if (cp_ch.code_point !== exp_item.code_point) begin
                    $error("code_point: expected %h, got %h",
                           exp_item.code_point, cp_ch.code_point);
                    fail_count++;
                end
                if (cp_ch.truncated !== exp_item.truncated) begin
                    $error("truncated: expected %b, got %b",
                           exp_item.truncated, cp_ch.truncated);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        byte_ch.valid        = 1'b0;
        byte_ch.data_byte    = '0;
        byte_ch.end_of_input = 1'b0;
        i_rst_n              = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_multibyte();
        test_end_of_input();
        // sender holds off here until the block has caught up
        drain_results();
        test_random_stream();

        // let anything in flight settle
        byte_ch.valid <= 1'b0;
        while (cp_expect_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("sent %0d bytes; checked %0d code points, %0d of them truncated",
                 bytes_sent, cps_checked, trunc_seen);
        $display("mixes covered: bursty sender with stalls, full rate, each side idling alone");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
design/u8d_pkg.sv
design/u8d_if.sv
design/u8d_step.sv
design/utf8_stream_decoder.sv
verif/utf8_stream_decoder_tb.sv
